// ===== rtl/core/ookft_pkg.sv =====
// ----------------------------------------------------------------------------
// ookft_pkg
// Shared types, register map and constants of the OOK frame transmitter.
// ----------------------------------------------------------------------------
package ookft_pkg;

	localparam int unsigned DATA_W        = 16;
	localparam int unsigned TICK_W        = 16;
	localparam int unsigned WORD_BITS_DEF = 16;
	localparam int unsigned MAX_WORD_BITS = 64;
	localparam int unsigned ADDR_W        = 5;
	localparam int unsigned APB_DATA_W    = 32;
	localparam int unsigned REG_IDX_W     = 3;

	localparam logic [REG_IDX_W-1:0] REG_AGC_SETTLE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AGC_GAP     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE_LOW  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BIT_TICKS   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LINE_MODE   = 3'd5;

	localparam logic [TICK_W-1:0] AGC_SETTLE_RST  = 16'd4000;
	localparam logic [TICK_W-1:0] AGC_GAP_RST     = 16'd500;
	localparam logic [TICK_W-1:0] ENABLE_HIGH_RST = 16'd2100;
	localparam logic [TICK_W-1:0] ENABLE_LOW_RST  = 16'd2100;
	localparam logic [TICK_W-1:0] BIT_TICKS_RST   = 16'd200;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_START   = 1'b1;
	localparam logic MODE_NRZ   = 1'b0;
	localparam logic MODE_MANCH = 1'b1;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_AGC  = 6'b000010,
		PH_GAP  = 6'b000100,
		PH_ENH  = 6'b001000,
		PH_ENL  = 6'b010000,
		PH_DATA = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] agc_settle_ticks;
		logic [TICK_W-1:0] agc_gap_ticks;
		logic [TICK_W-1:0] enable_high_ticks;
		logic [TICK_W-1:0] enable_low_ticks;
		logic [TICK_W-1:0] bit_ticks;
		logic              line_mode;
	} cfg_t;

	typedef struct packed {
		logic              opcode;
		logic [DATA_W-1:0] data_word;
	} item_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic frame_done;
		logic start_rejected;
	} res_t;

endpackage

// ===== rtl/core/ookft_tick_if.sv =====
// ----------------------------------------------------------------------------
// ookft_tick_if
// Input channel: one timing tick or frame start per beat.
// ----------------------------------------------------------------------------
interface ookft_tick_if;
	logic                valid;
	logic                ready;
	ookft_pkg::item_t    item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/ookft_res_if.sv =====
// ----------------------------------------------------------------------------
// ookft_res_if
// Result channel: carrier gate level and frame status per beat.
// ----------------------------------------------------------------------------
interface ookft_res_if;
	logic               valid;
	logic               ready;
	ookft_pkg::res_t    res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

// ===== rtl/core/ookft_regs.sv =====
// ----------------------------------------------------------------------------
// ookft_regs
// APB register file holding the frame timing and line mode settings.
// ----------------------------------------------------------------------------
module ookft_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ookft_pkg::ADDR_W-1:0]        paddr,
	input  logic [ookft_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ookft_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output ookft_pkg::cfg_t                     cfg
);
	import ookft_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.agc_settle_ticks  <= AGC_SETTLE_RST;
			cfg_q.agc_gap_ticks     <= AGC_GAP_RST;
			cfg_q.enable_high_ticks <= ENABLE_HIGH_RST;
			cfg_q.enable_low_ticks  <= ENABLE_LOW_RST;
			cfg_q.bit_ticks         <= BIT_TICKS_RST;
			cfg_q.line_mode         <= MODE_NRZ;
		end else if (wr_en) begin
			case (reg_idx)
				REG_AGC_SETTLE:  cfg_q.agc_settle_ticks  <= pwdata[TICK_W-1:0];
				REG_AGC_GAP:     cfg_q.agc_gap_ticks     <= pwdata[TICK_W-1:0];
				REG_ENABLE_HIGH: cfg_q.enable_high_ticks <= pwdata[TICK_W-1:0];
				REG_ENABLE_LOW:  cfg_q.enable_low_ticks  <= pwdata[TICK_W-1:0];
				REG_BIT_TICKS:   cfg_q.bit_ticks         <= pwdata[TICK_W-1:0];
				REG_LINE_MODE:   cfg_q.line_mode         <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_AGC_SETTLE:  prdata[TICK_W-1:0] = cfg_q.agc_settle_ticks;
			REG_AGC_GAP:     prdata[TICK_W-1:0] = cfg_q.agc_gap_ticks;
			REG_ENABLE_HIGH: prdata[TICK_W-1:0] = cfg_q.enable_high_ticks;
			REG_ENABLE_LOW:  prdata[TICK_W-1:0] = cfg_q.enable_low_ticks;
			REG_BIT_TICKS:   prdata[TICK_W-1:0] = cfg_q.bit_ticks;
			REG_LINE_MODE:   prdata[0]          = cfg_q.line_mode;
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/ookft_engine.sv =====
// ----------------------------------------------------------------------------
// ookft_engine
// Input register, frame sequencer state and result register.
// ----------------------------------------------------------------------------
module ookft_engine #(
	parameter int unsigned WORD_BITS = ookft_pkg::WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ookft_pkg::cfg_t  cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  ookft_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output ookft_pkg::res_t  out_res
);
	import ookft_pkg::*;

	localparam int unsigned BL_W = $clog2(WORD_BITS + 1);
	localparam logic [BL_W-1:0] BITS_INIT = BL_W'(WORD_BITS);

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  out_valid_q;
	res_t                  res_q;

	phase_t                phase_q,  phase_d;
	logic [TICK_W-1:0]     count_q,  count_d;
	logic [WORD_BITS-1:0]  shift_q,  shift_d;
	logic [BL_W-1:0]       bits_q,   bits_d;
	logic                  half_q,   half_d;

	logic                  advance;
	logic                  fire;
	logic                  active;
	logic                  level;
	logic [TICK_W-1:0]     len_raw;
	logic [TICK_W-1:0]     len;
	logic [TICK_W-1:0]     count_inc;
	logic                  end_phase;
	logic [MAX_WORD_BITS-1:0] data_ext;
	res_t                  res_d;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign active = (phase_q != PH_IDLE);
	assign data_ext = MAX_WORD_BITS'(item_s1.data_word);

	always_comb begin
		case (phase_q)
			PH_AGC:  len_raw = cfg.agc_settle_ticks;
			PH_GAP:  len_raw = cfg.agc_gap_ticks;
			PH_ENH:  len_raw = cfg.enable_high_ticks;
			PH_ENL:  len_raw = cfg.enable_low_ticks;
			default: len_raw = cfg.bit_ticks;
		endcase
		len = (len_raw == '0) ? TICK_W'(1) : len_raw;
	end

	assign count_inc = count_q + TICK_W'(1);
	assign end_phase = (count_inc == '0) || (count_inc >= len);

	always_comb begin
		case (phase_q)
			PH_AGC:  level = 1'b1;
			PH_ENH:  level = 1'b1;
			PH_DATA: begin
				if (cfg.line_mode == MODE_NRZ) begin
					level = shift_q[WORD_BITS-1];
				end else begin
					level = half_q ? shift_q[WORD_BITS-1] : !shift_q[WORD_BITS-1];
				end
			end
			default: level = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		half_d  = half_q;
		res_d   = '0;
		if (item_s1.opcode == OP_START) begin
			res_d.busy_res = 1'b1;
			if (active) begin
				res_d.start_rejected = 1'b1;
				res_d.carrier_on     = level;
			end else begin
				res_d.carrier_on = 1'b1;
				phase_d = PH_AGC;
				count_d = '0;
				shift_d = data_ext[WORD_BITS-1:0];
				bits_d  = BITS_INIT;
				half_d  = 1'b0;
			end
		end else if (active) begin
			res_d.busy_res   = 1'b1;
			res_d.carrier_on = level;
			count_d = count_inc;
			if (end_phase) begin
				count_d = '0;
				case (phase_q)
					PH_AGC: begin
						phase_d = PH_GAP;
						half_d  = 1'b0;
					end
					PH_GAP: begin
						phase_d = PH_ENH;
						half_d  = 1'b0;
					end
					PH_ENH: begin
						phase_d = PH_ENL;
						half_d  = 1'b0;
					end
					PH_ENL: begin
						phase_d = PH_DATA;
						half_d  = 1'b0;
					end
					default: begin
						if (cfg.line_mode == MODE_MANCH && !half_q) begin
							half_d = 1'b1;
						end else begin
							half_d  = 1'b0;
							shift_d = shift_q << 1;
							if (bits_q != '0) begin
								bits_d = bits_q - BL_W'(1);
							end
							if (bits_q <= BL_W'(1)) begin
								phase_d = PH_IDLE;
								res_d.frame_done = 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			half_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			half_q  <= half_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_done |-> res_q.busy_res)
		else $error("frame_done without busy");

	a_carrier_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.carrier_on |-> res_q.busy_res)
		else $error("carrier on outside a frame");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.start_rejected |-> res_q.busy_res && !res_q.frame_done)
		else $error("rejected start reported with wrong status");

	a_data_bits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bits_q != '0)
		else $error("data phase with no bits left");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(phase_q) && $stable(count_q))
		else $error("state moved while result stalled");
`endif

endmodule

// ===== rtl/core/ook_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// ook_frame_transmitter
// On-off-keyed frame sender: AGC preamble, enable pulse, then NRZ or
// Manchester data bits, one carrier gate level per timing tick.
//
//   channel  dir  handshake       payload
//   tick     in   valid / ready   item.opcode, item.data_word
//   result   out  valid / ready   res.carrier_on, busy_res, frame_done,
//                                 start_rejected
//   apb      in   psel / penable  paddr, pwdata, prdata (pready tied high)
//
// One beat is taken every cycle while the result side is not stalled; each beat
// passes through the input register and then the result register to the output.
// A stalled result beat holds the pipeline; the input side keeps one beat.
// Reset is asynchronous and restores the register defaults with the
// sequencer idle.
// ----------------------------------------------------------------------------
module ook_frame_transmitter #(
	parameter int unsigned WORD_BITS = ookft_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ookft_pkg::ADDR_W-1:0]     paddr,
	input  logic [ookft_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ookft_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	ookft_tick_if.sink                       tick,
	ookft_res_if.source                      result
);
	import ookft_pkg::*;

	cfg_t cfg;

	ookft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ookft_engine #(
		.WORD_BITS (WORD_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.in_item   (tick.item),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (result.res)
	);

endmodule
